@@ hw/rtl/ps2dec_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package ps2dec_pkg;

	// prefix and modifier scan codes, set 2
	localparam logic [7:0] SC_EXT    = 8'hE0;
	localparam logic [7:0] SC_REL    = 8'hF0;
	localparam logic [7:0] SC_LSHIFT = 8'h12;
	localparam logic [7:0] SC_RSHIFT = 8'h59;
	localparam logic [7:0] SC_CTRL   = 8'h14;
	localparam logic [7:0] SC_ALT    = 8'h11;
	localparam logic [7:0] SC_CAPS   = 8'h58;

	localparam logic [1:0] COMBO_PLAIN = 2'd0;
	localparam logic [1:0] COMBO_CTRL  = 2'd1;
	localparam logic [1:0] COMBO_ALT   = 2'd2;

	typedef struct packed {
		logic shift;
		logic ctrl;
		logic alt;
		logic caps;
	} held_keys_t;

	function automatic logic [6:0] plain_map(input logic [6:0] b);
		logic [6:0] c;
		case (b)
			7'h1C: c = 7'h61;
			7'h32: c = 7'h62;
			7'h21: c = 7'h63;
			7'h23: c = 7'h64;
			7'h24: c = 7'h65;
			7'h2B: c = 7'h66;
			7'h34: c = 7'h67;
			7'h33: c = 7'h68;
			7'h43: c = 7'h69;
			7'h3B: c = 7'h6A;
			7'h42: c = 7'h6B;
			7'h4B: c = 7'h6C;
			7'h3A: c = 7'h6D;
			7'h31: c = 7'h6E;
			7'h44: c = 7'h6F;
			7'h4D: c = 7'h70;
			7'h15: c = 7'h71;
			7'h2D: c = 7'h72;
			7'h1B: c = 7'h73;
			7'h2C: c = 7'h74;
			7'h3C: c = 7'h75;
			7'h2A: c = 7'h76;
			7'h1D: c = 7'h77;
			7'h22: c = 7'h78;
			7'h35: c = 7'h79;
			7'h1A: c = 7'h7A;
			7'h16: c = 7'h31;
			7'h1E: c = 7'h32;
			7'h26: c = 7'h33;
			7'h25: c = 7'h34;
			7'h2E: c = 7'h35;
			7'h36: c = 7'h36;
			7'h3D: c = 7'h37;
			7'h3E: c = 7'h38;
			7'h46: c = 7'h39;
			7'h45: c = 7'h30;
			7'h0E: c = 7'h60;
			7'h4E: c = 7'h2D;
			7'h55: c = 7'h3D;
			7'h54: c = 7'h5B;
			7'h5B: c = 7'h5D;
			7'h5D: c = 7'h5C;
			7'h4C: c = 7'h3B;
			7'h52: c = 7'h27;
			7'h41: c = 7'h2C;
			7'h49: c = 7'h2E;
			7'h4A: c = 7'h2F;
			7'h29: c = 7'h20;
			7'h5A: c = 7'h0A;
			7'h66: c = 7'h08;
			7'h0D: c = 7'h09;
			7'h76: c = 7'h1B;
			7'h70: c = 7'h30;
			7'h69: c = 7'h31;
			7'h72: c = 7'h32;
			7'h7A: c = 7'h33;
			7'h6B: c = 7'h34;
			7'h73: c = 7'h35;
			7'h74: c = 7'h36;
			7'h6C: c = 7'h37;
			7'h75: c = 7'h38;
			7'h7D: c = 7'h39;
			7'h7C: c = 7'h2A;
			7'h7B: c = 7'h2D;
			7'h79: c = 7'h2B;
			7'h71: c = 7'h2E;
			default: c = 7'h00;
		endcase
		return c;
	endfunction

	// zero means shift leaves the key alone; letters are zero here yet still change case with shift
	function automatic logic [6:0] shift_map(input logic [6:0] b);
		logic [6:0] c;
		case (b)
			7'h16: c = 7'h21;
			7'h1E: c = 7'h40;
			7'h26: c = 7'h23;
			7'h25: c = 7'h24;
			7'h2E: c = 7'h25;
			7'h36: c = 7'h5E;
			7'h3D: c = 7'h26;
			7'h3E: c = 7'h2A;
			7'h46: c = 7'h28;
			7'h45: c = 7'h29;
			7'h0E: c = 7'h7E;
			7'h4E: c = 7'h5F;
			7'h55: c = 7'h2B;
			7'h54: c = 7'h7B;
			7'h5B: c = 7'h7D;
			7'h5D: c = 7'h7C;
			7'h4C: c = 7'h3A;
			7'h52: c = 7'h22;
			7'h41: c = 7'h3C;
			7'h49: c = 7'h3E;
			7'h4A: c = 7'h3F;
			default: c = 7'h00;
		endcase
		return c;
	endfunction

	function automatic logic [6:0] ext_map(input logic [7:0] b);
		logic [6:0] c;
		case (b)
			8'h75: c = 7'h5E;
			8'h72: c = 7'h76;
			8'h6B: c = 7'h3C;
			8'h74: c = 7'h3E;
			8'h70: c = 7'h30;
			8'h71: c = 7'h2E;
			8'h6C: c = 7'h37;
			8'h69: c = 7'h31;
			8'h7D: c = 7'h39;
			8'h7A: c = 7'h33;
			8'h4A: c = 7'h2F;
			8'h5A: c = 7'h0A;
			default: c = 7'h00;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

@@ hw/rtl/ps2dec_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface ps2dec_scan_if;
	logic       valid;
	logic       ready;
	logic [7:0] scan_byte;

	modport source (output valid, output scan_byte, input ready);
	modport sink (input valid, input scan_byte, output ready);
endinterface

interface ps2dec_char_if;
	logic       valid;
	logic       ready;
	logic [6:0] char_code;
	logic [1:0] combo_kind;

	modport source (output valid, output char_code, output combo_kind, input ready);
	modport sink (input valid, input char_code, input combo_kind, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/ps2_scancode_to_ascii_decoder.sv @@
`timescale 1ns / 1ps
`default_nettype none

// channel | dir | payload                    | meaning
// scan    | in  | scan_byte[7:0]             | set 2 scan byte, E0/F0 prefixes included
// ascii   | out | char_code[6:0], combo_kind | decoded character and combination kind
//
// one item per cycle sustained while no result stalls; each byte passes the input register, then the result register
// prefix state and modifier flags update as each byte leaves the input register
// arst_n clears the prefix and modifier flags and both valid bits
// a stalled result holds the input register; scan.ready then drops once it is full

module ps2_scancode_to_ascii_decoder
	import ps2dec_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	ps2dec_scan_if.sink    scan,
	ps2dec_char_if.source  ascii
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       ext_q;
	logic       rel_q;
	held_keys_t held_q;
	logic       out_valid_q;
	logic [6:0] char_q;
	logic [1:0] kind_q;

	logic       advance;
	logic       is_prefix;
	logic       is_shift;
	logic       is_mod;
	logic       emit;
	logic [6:0] map_char;
	logic [1:0] map_kind;

	assign advance   = valid_s1 && (!out_valid_q || ascii.ready);
	assign scan.ready = !valid_s1 || advance;

	assign is_prefix = (byte_s1 == SC_EXT) || (byte_s1 == SC_REL);
	assign is_shift  = (byte_s1 == SC_LSHIFT) || (byte_s1 == SC_RSHIFT);
	assign is_mod    = is_shift || (byte_s1 == SC_CTRL) || (byte_s1 == SC_ALT)
		|| (byte_s1 == SC_CAPS);
	assign emit      = !is_prefix && !rel_q && !is_mod && (map_char != 7'h00);

	ps2dec_keymap u_keymap (
		.scan_byte  (byte_s1),
		.ext        (ext_q),
		.held       (held_q),
		.char_code  (map_char),
		.combo_kind (map_kind)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (scan.ready) begin
			valid_s1 <= scan.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (scan.valid && scan.ready) begin
			byte_s1 <= scan.scan_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ext_q  <= 1'b0;
			rel_q  <= 1'b0;
			held_q <= '0;
		end else if (advance) begin
			if (byte_s1 == SC_EXT) begin
				ext_q <= 1'b1;
			end else if (byte_s1 == SC_REL) begin
				rel_q <= 1'b1;
			end else begin
				ext_q <= 1'b0;
				if (rel_q) begin
					rel_q <= 1'b0;
					if (is_shift) held_q.shift <= 1'b0;
					else if (byte_s1 == SC_CTRL) held_q.ctrl <= 1'b0;
					else if (byte_s1 == SC_ALT) held_q.alt <= 1'b0;
				end else begin
					if (byte_s1 == SC_CAPS) held_q.caps <= !held_q.caps;
					else if (is_shift) held_q.shift <= 1'b1;
					else if (byte_s1 == SC_CTRL) held_q.ctrl <= 1'b1;
					else if (byte_s1 == SC_ALT) held_q.alt <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= emit;
		end else if (ascii.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			char_q <= map_char;
			kind_q <= map_kind;
		end
	end

	assign ascii.valid      = out_valid_q;
	assign ascii.char_code  = char_q;
	assign ascii.combo_kind = kind_q;

	a_no_zero_char: assert property (@(posedge clk) disable iff (!arst_n)
		ascii.valid |-> (ascii.char_code != 7'h00))
		else $error("zero character presented");

	a_rel_sets_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && (byte_s1 == SC_REL)) |=> rel_q)
		else $error("release prefix not recorded");

	a_ctrl_range: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && emit && held_q.ctrl && !ext_q) |=>
		(ascii.combo_kind == COMBO_CTRL))
		else $error("ctrl combination not flagged");

	a_stall_holds_input: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(byte_s1)))
		else $error("input register lost an item while stalled");

endmodule

`default_nettype wire

@@ hw/rtl/ps2dec_keymap.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ps2dec_keymap
	import ps2dec_pkg::*;
(
	input  wire logic [7:0] scan_byte,
	input  wire logic       ext,
	input  wire held_keys_t held,
	output logic [6:0]      char_code,
	output logic [1:0]      combo_kind
);

	logic [6:0] plain_c;
	logic [6:0] shift_c;
	logic [6:0] base_c;
	logic       is_lower;
	logic       is_upper;

	assign plain_c = scan_byte[7] ? 7'h00 : plain_map(scan_byte[6:0]);
	assign shift_c = scan_byte[7] ? 7'h00 : shift_map(scan_byte[6:0]);
	assign is_lower = (plain_c >= 7'h61) && (plain_c <= 7'h7A);

	always_comb begin
		if (ext) begin
			base_c = ext_map(scan_byte);
		end else if (is_lower) begin
			// upper case when caps and shift disagree
			base_c = (held.shift != held.caps) ? (plain_c - 7'h20) : plain_c;
		end else if (held.shift && (shift_c != 7'h00)) begin
			base_c = shift_c;
		end else begin
			base_c = plain_c;
		end
	end

	assign is_upper = (base_c >= 7'h41) && (base_c <= 7'h5A);

	always_comb begin
		char_code  = base_c;
		combo_kind = COMBO_PLAIN;
		if (held.ctrl && !ext) begin
			// low five bits of a letter give 1..26 for either case
			if (is_upper || ((base_c >= 7'h61) && (base_c <= 7'h7A))) begin
				char_code = {2'b00, base_c[4:0]};
			end
			combo_kind = COMBO_CTRL;
		end else if (held.alt && !ext) begin
			combo_kind = COMBO_ALT;
		end
	end

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
	import ps2dec_pkg::*;

	localparam int CYCLE_LIMIT = 200000;

	logic clk;
	logic arst_n;

	ps2dec_scan_if scan();
	ps2dec_char_if ascii();

	ps2_scancode_to_ascii_decoder dut (
		.clk(clk),
		.arst_n(arst_n),
		.scan(scan),
		.ascii(ascii)
	);

	typedef struct {
		logic [6:0] code;
		logic [1:0] kind;
	} char_item_t;

	// unshifted character of a non-extended key, zero when unmapped
	function automatic logic [7:0] key_base(input logic [6:0] b);
		logic [7:0] c;
		case (b)
			7'h1C: c = "a";  7'h32: c = "b";  7'h21: c = "c";  7'h23: c = "d";
			7'h24: c = "e";  7'h2B: c = "f";  7'h34: c = "g";  7'h33: c = "h";
			7'h43: c = "i";  7'h3B: c = "j";  7'h42: c = "k";  7'h4B: c = "l";
			7'h3A: c = "m";  7'h31: c = "n";  7'h44: c = "o";  7'h4D: c = "p";
			7'h15: c = "q";  7'h2D: c = "r";  7'h1B: c = "s";  7'h2C: c = "t";
			7'h3C: c = "u";  7'h2A: c = "v";  7'h1D: c = "w";  7'h22: c = "x";
			7'h35: c = "y";  7'h1A: c = "z";
			7'h16: c = "1";  7'h1E: c = "2";  7'h26: c = "3";  7'h25: c = "4";
			7'h2E: c = "5";  7'h36: c = "6";  7'h3D: c = "7";  7'h3E: c = "8";
			7'h46: c = "9";  7'h45: c = "0";
			7'h0E: c = 8'h60; // backquote
			7'h4E: c = "-";  7'h55: c = "=";  7'h54: c = "[";  7'h5B: c = "]";
			7'h5D: c = "\\"; 7'h4C: c = ";";  7'h52: c = "'";  7'h41: c = ",";
			7'h49: c = ".";  7'h4A: c = "/";
			7'h29: c = " ";  7'h5A: c = 8'h0A; 7'h66: c = 8'h08; 7'h0D: c = 8'h09;
			7'h76: c = 8'h1B;
			// keypad
			7'h70: c = "0";  7'h69: c = "1";  7'h72: c = "2";  7'h7A: c = "3";
			7'h6B: c = "4";  7'h73: c = "5";  7'h74: c = "6";  7'h6C: c = "7";
			7'h75: c = "8";  7'h7D: c = "9";  7'h7C: c = "*";  7'h7B: c = "-";
			7'h79: c = "+";  7'h71: c = ".";
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] key_shifted(input logic [6:0] b);
		logic [7:0] c;
		case (b)
			7'h16: c = "!";  7'h1E: c = "@";  7'h26: c = "#";  7'h25: c = "$";
			7'h2E: c = "%";  7'h36: c = "^";  7'h3D: c = "&";  7'h3E: c = "*";
			7'h46: c = "(";  7'h45: c = ")";  7'h0E: c = "~";  7'h4E: c = "_";
			7'h55: c = "+";  7'h54: c = "{";  7'h5B: c = "}";  7'h5D: c = "|";
			7'h4C: c = ":";  7'h52: c = "\""; 7'h41: c = "<";  7'h49: c = ">";
			7'h4A: c = "?";
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] key_extended(input logic [7:0] b);
		logic [7:0] c;
		case (b)
			8'h75: c = "^";  8'h72: c = "v";  8'h6B: c = "<";  8'h74: c = ">";
			8'h70: c = "0";  8'h71: c = ".";  8'h6C: c = "7";  8'h69: c = "1";
			8'h7D: c = "9";  8'h7A: c = "3";  8'h4A: c = "/";  8'h5A: c = 8'h0A;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] key_char(input logic [7:0] b, input bit ext,
			input bit shift_on, input bit caps_on);
		logic [7:0] c;
		logic [7:0] s;
		if (ext)
			return key_extended(b);
		if (b[7])
			return 8'h00;
		c = key_base(b[6:0]);
		s = key_shifted(b[6:0]);
		if (c >= "a" && c <= "z")
			return (shift_on ^ caps_on) ? c - 8'd32 : c;
		if (shift_on && s != 8'h00)
			return s;
		return c;
	endfunction

	class char_scoreboard;
		bit ext_pending, rel_pending, shift_on, ctrl_on, alt_on, caps_on;
		char_item_t expected_chars[$];
		int unsigned errors;

		function void note_scan(input logic [7:0] b);
			bit ext;
			logic [7:0] c;
			logic [1:0] kind;
			char_item_t item;
			if (b == SC_EXT) begin
				ext_pending = 1'b1;
			end else if (b == SC_REL) begin
				rel_pending = 1'b1;
			end else begin
				ext = ext_pending;
				ext_pending = 1'b0;
				if (rel_pending) begin
					rel_pending = 1'b0;
					if (b == SC_LSHIFT || b == SC_RSHIFT)
						shift_on = 1'b0;
					else if (b == SC_CTRL)
						ctrl_on = 1'b0;
					else if (b == SC_ALT)
						alt_on = 1'b0;
				end else if (b == SC_CAPS) begin
					caps_on = !caps_on;
				end else if (b == SC_LSHIFT || b == SC_RSHIFT) begin
					shift_on = 1'b1;
				end else if (b == SC_CTRL) begin
					ctrl_on = 1'b1;
				end else if (b == SC_ALT) begin
					alt_on = 1'b1;
				end else begin
					c = key_char(b, ext, shift_on, caps_on);
					kind = COMBO_PLAIN;
					// extended keys ignore ctrl and alt
					if (ctrl_on && !ext) begin
						if (c >= "a" && c <= "z")
							c = c - "a" + 8'd1;
						else if (c >= "A" && c <= "Z")
							c = c - "A" + 8'd1;
						kind = COMBO_CTRL;
					end else if (alt_on && !ext) begin
						kind = COMBO_ALT;
					end
					if (c != 8'h00) begin
						item.code = c[6:0];
						item.kind = kind;
						expected_chars.push_back(item);
					end
				end
			end
		endfunction

		function void check_char(input logic [6:0] code, input logic [1:0] kind);
			char_item_t want;
			if (expected_chars.size() == 0) begin
				$error("unexpected item: char_code %h combo_kind %0d", code, kind);
				errors++;
				return;
			end
			want = expected_chars.pop_front();
			if (code !== want.code) begin
				$error("char_code expected %h actual %h", want.code, code);
				errors++;
			end
			if (kind !== want.kind) begin
				$error("combo_kind expected %0d actual %0d", want.kind, kind);
				errors++;
			end
		endfunction
	endclass

	char_scoreboard sb = new();

	int key_items;
	bit quiet;
	int cycle_count;
	logic [7:0] plain_keys[$];
	logic [7:0] ext_keys[14] = '{8'h75, 8'h72, 8'h6B, 8'h74, 8'h70, 8'h71, 8'h6C,
		8'h69, 8'h7D, 8'h7A, 8'h4A, 8'h5A, 8'h1C, 8'h29};
	logic [7:0] mod_keys[4] = '{SC_LSHIFT, SC_RSHIFT, SC_CTRL, SC_ALT};

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("ps2_scancode_to_ascii_decoder verification failed");
			$finish;
		end
	end

	task automatic send_scan(input logic [7:0] b);
		while (!quiet && $urandom_range(0, 99) < 31) begin
			scan.valid <= 1'b0;
			@(posedge clk);
		end
		scan.valid <= 1'b1;
		scan.scan_byte <= b;
		do @(posedge clk); while (!scan.ready);
		sb.note_scan(b);
		key_items++;
		// a long stretch with no idling on either side
		quiet = key_items >= 900 && key_items < 1300;
	endtask

	task automatic send_random_sequence();
		int pick;
		logic [7:0] k;
		pick = $urandom_range(0, 99);
		if (pick < 40) begin
			k = plain_keys[$urandom_range(0, plain_keys.size() - 1)];
			send_scan(k);
			if ($urandom_range(0, 1)) begin
				send_scan(SC_REL);
				send_scan(k);
			end
		end else if (pick < 52) begin
			k = ext_keys[$urandom_range(0, 13)];
			send_scan(SC_EXT);
			send_scan(k);
			if ($urandom_range(0, 1)) begin
				send_scan(SC_EXT);
				send_scan(SC_REL);
				send_scan(k);
			end
		end else if (pick < 65) begin
			k = mod_keys[$urandom_range(0, 3)];
			if ($urandom_range(0, 1))
				send_scan(SC_EXT);
			send_scan(k);
		end else if (pick < 80) begin
			k = mod_keys[$urandom_range(0, 3)];
			case ($urandom_range(0, 2))
				0: send_scan(SC_REL);
				1: begin
					send_scan(SC_EXT);
					send_scan(SC_REL);
				end
				default: begin
					send_scan(SC_REL);
					send_scan(SC_EXT);
				end
			endcase
			send_scan(k);
		end else if (pick < 85) begin
			send_scan(SC_CAPS);
			if ($urandom_range(0, 1)) begin
				send_scan(SC_REL);
				send_scan(SC_CAPS);
			end
		end else if (pick < 95) begin
			send_scan(8'($urandom_range(0, 255)));
		end else begin
			// stray or repeated prefixes ahead of an arbitrary byte
			repeat ($urandom_range(1, 3))
				send_scan($urandom_range(0, 1) ? SC_EXT : SC_REL);
			send_scan(8'($urandom_range(0, 255)));
		end
	endtask

	initial begin
		ascii.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && ascii.valid && ascii.ready)
				sb.check_char(ascii.char_code, ascii.combo_kind);
			ascii.ready <= quiet || $urandom_range(0, 99) >= 31;
		end
	end

	initial begin
		logic [7:0] directed_seq[] = '{
			8'h1C, 8'h1A, 8'h16, 8'h0E, 8'h5D, 8'h52, 8'h00, 8'h7F, 8'h80, 8'hFF,
			SC_LSHIFT, 8'h1C, 8'h16, 8'h4A, 8'h29, 8'h5A, 8'h66, 8'h0D, 8'h76, 8'h70,
			SC_REL, SC_LSHIFT,
			SC_CAPS, 8'h1C, SC_RSHIFT, 8'h1C, 8'h45, SC_REL, SC_RSHIFT,
			SC_REL, SC_CAPS, SC_CAPS,
			SC_CTRL, 8'h1C, 8'h1A, 8'h16, SC_ALT, 8'h15, SC_EXT, 8'h75,
			SC_EXT, SC_REL, SC_CTRL, 8'h1C, SC_REL, SC_EXT, SC_ALT,
			SC_EXT, 8'h72, SC_EXT, 8'h6B, SC_EXT, 8'h74, SC_EXT, 8'h70,
			SC_EXT, 8'h71, SC_EXT, 8'h6C, SC_EXT, 8'h69, SC_EXT, 8'h7D,
			SC_EXT, 8'h7A, SC_EXT, 8'h4A, SC_EXT, 8'h5A, SC_EXT, 8'h1C, 8'h1C,
			SC_EXT, SC_EXT, SC_REL, SC_REL, 8'h1C, 8'h1C,
			SC_EXT, SC_LSHIFT, 8'h4D, SC_REL, SC_EXT, SC_LSHIFT, 8'h4D
		};
		arst_n = 1'b0;
		scan.valid <= 1'b0;
		scan.scan_byte <= 8'h00;
		for (int i = 0; i < 128; i++)
			if (key_base(7'(i)) != 8'h00)
				plain_keys.push_back(8'(i));
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_seq[i])
			send_scan(directed_seq[i]);
		while (key_items < 2000)
			send_random_sequence();
		scan.valid <= 1'b0;

		while (sb.expected_chars.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (sb.errors == 0)
			$display("ps2_scancode_to_ascii_decoder verification clean");
		else
			$display("ps2_scancode_to_ascii_decoder verification failed");
		$finish;
	end

endmodule

@@ ps2_scancode_to_ascii_decoder.f @@
hw/rtl/ps2dec_pkg.sv
hw/rtl/ps2dec_if.sv
hw/rtl/ps2dec_keymap.sv
hw/rtl/ps2_scancode_to_ascii_decoder.sv
tb/testbench.sv
